/* rtl/core/julian_day_to_day_of_year_assert.svh */
// Assertion macros for the Julian date decoder.
// Each check takes a label, the clock, the reset, a condition and a consequence.
`ifndef JULIAN_DAY_TO_DAY_OF_YEAR_ASSERT_SVH
`define JULIAN_DAY_TO_DAY_OF_YEAR_ASSERT_SVH
`ifndef SYNTH
`define JDOY_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: same-cycle check failed");
`define JDOY_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");
`else
`define JDOY_ASSERT_SAME(label, clk, rst, ante, cons)
`define JDOY_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* rtl/core/jdoy_pkg.sv */
package jdoy_pkg;

   // Field widths.
   localparam int FRAC_BITS = 16;
   localparam int JD_W      = 39;
   localparam int CUT_W     = 23;
   localparam int DOY_W     = 9;
   localparam int MON_W     = 4;
   localparam int DOM_W     = 5;
   localparam int HOUR_W    = 5;
   localparam int MIN_W     = 6;

   localparam logic [CUT_W-1:0] CUTOVER_RESET = CUT_W'(2361221);

   // Pipeline depth.
   localparam int STAGES = 8;

   // Day number after adding half a day; one bit wider than the integer part.
   localparam int DAY_W = JD_W - FRAC_BITS + 1;
   localparam int X0_W  = DAY_W + 1;
   localparam longint unsigned DAY_BIAS = 68569;
   localparam longint unsigned JUL_BIAS = 38;

   // Four-century cycle split, floor(4 * x0 / cycle) by reciprocal multiply.
   localparam longint unsigned CYCLE_GREG = 146097;
   localparam longint unsigned CYCLE_JUL  = 146100;
   localparam int CYC_W   = 18;
   localparam int Z_SHIFT = X0_W + CYC_W;
   localparam longint unsigned Z_MUL_GREG =
      ((64'd4 << Z_SHIFT) + CYCLE_GREG - 1) / CYCLE_GREG;
   localparam longint unsigned Z_MUL_JUL =
      ((64'd4 << Z_SHIFT) + CYCLE_JUL - 1) / CYCLE_JUL;
   localparam int ZM_W = $clog2(Z_MUL_GREG + 1);
   localparam int ZP_W = X0_W + ZM_W;
   localparam int Z_W  = ZP_W - Z_SHIFT;
   localparam int R_W  = X0_W + 2;
   localparam int X1_W = CYC_W - 2;

   // Year within the cycle, floor(4000 * (x1 + 1) / 1461001).
   localparam int N1_W = X1_W + 1;
   localparam longint unsigned YEAR_NUM = 4000;
   localparam longint unsigned YEAR_DEN = 1461001;
   localparam int YDEN_W  = 21;
   localparam int Y_SHIFT = N1_W + YDEN_W;
   localparam longint unsigned Y_MUL =
      ((YEAR_NUM << Y_SHIFT) + YEAR_DEN - 1) / YEAR_DEN;
   localparam int YM_W = $clog2(Y_MUL + 1);
   localparam int YP_W = N1_W + YM_W;
   localparam int Y_W  = YP_W - Y_SHIFT;
   localparam int YEAR_DAYS4 = 1461;
   localparam int DAY_OFFSET = 31;
   localparam int XC_W = 11 + Y_W + 1;
   localparam int X2_W = X1_W + 1;

   // Month index, floor(80 * x2 / 2447).
   localparam longint unsigned MONTH_NUM = 80;
   localparam longint unsigned MONTH_DEN = 2447;
   localparam int MDEN_W  = 12;
   localparam int M_SHIFT = X2_W + MDEN_W;
   localparam longint unsigned M_MUL =
      ((MONTH_NUM << M_SHIFT) + MONTH_DEN - 1) / MONTH_DEN;
   localparam int MM_W = $clog2(M_MUL + 1);
   localparam int MP_W = X2_W + MM_W;
   localparam int MR_W = 4;

   typedef struct packed {
      logic [STAGES-1:0] load;
   } pipe_ctrl_type;

   typedef struct packed {
      logic [X0_W-1:0]      x0;
      logic                 julian;
      logic                 leap;
      logic [FRAC_BITS-1:0] frac;
   } split_type;

   typedef struct packed {
      logic [X1_W-1:0]      x1;
      logic                 leap;
      logic [FRAC_BITS-1:0] frac;
   } cycle_type;

   typedef struct packed {
      logic [X2_W-1:0]      x2;
      logic                 leap;
      logic [FRAC_BITS-1:0] frac;
   } year_type;

endpackage

/* rtl/core/jdoy_if.sv */
interface jdoy_req_if;
   import jdoy_pkg::*;

   logic            valid;
   logic            ready;
   logic [JD_W-1:0] julian_date;
   logic            leap_year;

   modport source (output valid, output julian_date, output leap_year, input ready);
   modport sink   (input valid, input julian_date, input leap_year, output ready);
endinterface

interface jdoy_rsp_if;
   import jdoy_pkg::*;

   logic              valid;
   logic              ready;
   logic [DOY_W-1:0]  year_day;
   logic [MON_W-1:0]  month;
   logic [DOM_W-1:0]  day_of_month;
   logic [HOUR_W-1:0] hour;
   logic [MIN_W-1:0]  minute;

   modport source (output valid, output year_day, output month, output day_of_month,
                   output hour, output minute, input ready);
   modport sink   (input valid, input year_day, input month, input day_of_month,
                   input hour, input minute, output ready);
endinterface

/* rtl/core/jdoy_day_split.sv */
module jdoy_day_split (
   input  logic                        clock,
   input  jdoy_pkg::pipe_ctrl_type     ctrl,
   input  logic [jdoy_pkg::JD_W-1:0]   julian_date,
   input  logic                        leap_year,
   input  logic [jdoy_pkg::CUT_W-1:0]  cutover,
   output jdoy_pkg::split_type         split
);
   import jdoy_pkg::*;

   localparam logic [JD_W:0] HALF_DAY = (JD_W+1)'(64'd1 << (FRAC_BITS - 1));

   logic [JD_W:0]          shifted;
   logic [DAY_W-1:0]       day_in, day_ff;
   logic [FRAC_BITS-1:0]   frac_in, frac_ff;
   logic                   leap_ff;
   logic                   julian;
   split_type              split_in, split_ff;

   // Stage 0: add half a day and split into day number and fraction.
   always_comb begin
      shifted = {1'b0, julian_date} + HALF_DAY;
      day_in  = shifted[JD_W:FRAC_BITS];
      frac_in = shifted[FRAC_BITS-1:0];
   end

   // Stage 1: calendar choice and biased day number.
   always_comb begin
      julian          = day_ff <= DAY_W'(cutover);
      split_in.julian = julian;
      split_in.x0     = X0_W'(day_ff) + X0_W'(DAY_BIAS) +
                        (julian ? X0_W'(JUL_BIAS) : X0_W'(0));
      split_in.leap   = leap_ff;
      split_in.frac   = frac_ff;
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[0]) begin
         day_ff  <= day_in;
         frac_ff <= frac_in;
         leap_ff <= leap_year;
      end
      if (ctrl.load[1]) begin
         split_ff <= split_in;
      end
   end

   assign split = split_ff;
endmodule

/* rtl/core/jdoy_cycle_div.sv */
module jdoy_cycle_div (
   input  logic                    clock,
   input  jdoy_pkg::pipe_ctrl_type ctrl,
   input  jdoy_pkg::split_type     split,
   output jdoy_pkg::cycle_type     cycle
);
   import jdoy_pkg::*;

   logic [ZP_W-1:0]  z_prod;
   logic [Z_W-1:0]   z_in, z_ff;
   split_type        split_ff;
   logic [R_W-1:0]   four_x;
   logic [R_W-1:0]   whole;
   logic [R_W-1:0]   rem;
   cycle_type        cycle_in, cycle_ff;

   // Stage 2: cycle count as a multiply by the rounded-up reciprocal.
   always_comb begin
      z_prod = ZP_W'(split.x0) *
               (split.julian ? ZP_W'(Z_MUL_JUL) : ZP_W'(Z_MUL_GREG));
      z_in   = z_prod[ZP_W-1:Z_SHIFT];
   end

   // Stage 3: the day within the cycle is the remainder divided by four.
   always_comb begin
      four_x         = {split_ff.x0, 2'b00};
      whole          = R_W'(z_ff) *
                       (split_ff.julian ? R_W'(CYCLE_JUL) : R_W'(CYCLE_GREG));
      rem            = four_x - whole;
      cycle_in.x1    = rem[X1_W+1:2];
      cycle_in.leap  = split_ff.leap;
      cycle_in.frac  = split_ff.frac;
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[2]) begin
         z_ff     <= z_in;
         split_ff <= split;
      end
      if (ctrl.load[3]) begin
         cycle_ff <= cycle_in;
      end
   end

   assign cycle = cycle_ff;
endmodule

/* rtl/core/jdoy_year_div.sv */
module jdoy_year_div (
   input  logic                    clock,
   input  jdoy_pkg::pipe_ctrl_type ctrl,
   input  jdoy_pkg::cycle_type     cycle,
   output jdoy_pkg::year_type      year
);
   import jdoy_pkg::*;

   logic [N1_W-1:0] n1;
   logic [YP_W-1:0] y_prod;
   logic [Y_W-1:0]  y_in, y_ff;
   cycle_type       cycle_ff;
   logic [XC_W-1:0] year_start;
   logic [XC_W-1:0] x2_wide;
   year_type        year_in, year_ff;

   // Stage 4: year within the cycle.
   always_comb begin
      n1     = N1_W'(cycle.x1) + N1_W'(1);
      y_prod = YP_W'(n1) * YP_W'(Y_MUL);
      y_in   = y_prod[YP_W-1:Y_SHIFT];
   end

   // Stage 5: day index within the year, offset so that 31 falls on the first of March.
   always_comb begin
      year_start   = (XC_W'(y_ff) * XC_W'(YEAR_DAYS4)) >> 2;
      x2_wide      = XC_W'(cycle_ff.x1) + XC_W'(DAY_OFFSET) - year_start;
      year_in.x2   = x2_wide[X2_W-1:0];
      year_in.leap = cycle_ff.leap;
      year_in.frac = cycle_ff.frac;
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[4]) begin
         y_ff     <= y_in;
         cycle_ff <= cycle;
      end
      if (ctrl.load[5]) begin
         year_ff <= year_in;
      end
   end

   assign year = year_ff;
endmodule

/* rtl/core/jdoy_month_dec.sv */
module jdoy_month_dec (
   input  logic                        clock,
   input  jdoy_pkg::pipe_ctrl_type     ctrl,
   input  jdoy_pkg::year_type          year,
   output logic [jdoy_pkg::DOY_W-1:0]  year_day,
   output logic [jdoy_pkg::MON_W-1:0]  month,
   output logic [jdoy_pkg::DOM_W-1:0]  day_of_month
);
   import jdoy_pkg::*;

   localparam int SUB_W = 9;
   localparam logic [MON_W-1:0] MON_FEB = MON_W'(2);
   localparam logic [MON_W-1:0] MON_DEC = MON_W'(12);

   // Calendar month for each raw month index (index one is March).
   localparam logic [MON_W-1:0] MONTH_OF_IDX [16] = '{
      4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9,
      4'd10, 4'd11, 4'd12, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5
   };
   // floor(2447 * index / 80): the day index just before the month's first day.
   localparam logic [SUB_W-1:0] DAYS_BEFORE_IDX [16] = '{
      9'd0, 9'd30, 9'd61, 9'd91, 9'd122, 9'd152, 9'd183, 9'd214,
      9'd244, 9'd275, 9'd305, 9'd336, 9'd367, 9'd397, 9'd428, 9'd458
   };
   // Days before each calendar month in a common year; zero outside one to twelve.
   localparam logic [DOY_W-1:0] CUM_DAYS [16] = '{
      9'd0, 9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
      9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd0, 9'd0, 9'd0
   };

   logic [MP_W-1:0]   m_prod;
   logic [MR_W-1:0]   idx_in, idx_ff;
   year_type          year_ff;
   logic [MON_W-1:0]  month_in, month_ff;
   logic [X2_W-1:0]   dom_wide;
   logic [DOM_W-1:0]  dom_in, dom_ff;
   logic [DOY_W-1:0]  doy_in, doy_ff;
   logic              leap_day;

   // Stage 6: raw month index.
   always_comb begin
      m_prod = MP_W'(year.x2) * MP_W'(M_MUL);
      idx_in = m_prod[M_SHIFT +: MR_W];
   end

   // Stage 7: month, day of month and day of year.
   always_comb begin
      month_in = MONTH_OF_IDX[idx_ff];
      dom_wide = year_ff.x2 - X2_W'(DAYS_BEFORE_IDX[idx_ff]);
      dom_in   = dom_wide[DOM_W-1:0];
      leap_day = year_ff.leap && (month_in > MON_FEB) && (month_in <= MON_DEC);
      doy_in   = dom_wide[DOY_W-1:0] + CUM_DAYS[month_in] + DOY_W'(leap_day);
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[6]) begin
         idx_ff  <= idx_in;
         year_ff <= year;
      end
      if (ctrl.load[7]) begin
         month_ff <= month_in;
         dom_ff   <= dom_in;
         doy_ff   <= doy_in;
      end
   end

   assign year_day     = doy_ff;
   assign month        = month_ff;
   assign day_of_month = dom_ff;
endmodule

/* rtl/core/jdoy_clock_dec.sv */
module jdoy_clock_dec (
   input  logic                         clock,
   input  jdoy_pkg::pipe_ctrl_type      ctrl,
   input  logic [jdoy_pkg::FRAC_BITS-1:0] frac,
   output logic [jdoy_pkg::HOUR_W-1:0]  hour,
   output logic [jdoy_pkg::MIN_W-1:0]   minute
);
   import jdoy_pkg::*;

   localparam int H_W = FRAC_BITS + HOUR_W;
   localparam int M_W = FRAC_BITS + MIN_W;
   localparam logic [H_W-1:0] HOURS_PER_DAY    = H_W'(24);
   localparam logic [M_W-1:0] MINUTES_PER_HOUR = M_W'(60);

   logic [H_W-1:0]       h_prod;
   logic [HOUR_W-1:0]    hour_in, hour_ff, hour_out_ff;
   logic [FRAC_BITS-1:0] rest_in, rest_ff;
   logic [M_W-1:0]       m_prod;
   logic [MIN_W-1:0]     minute_in, minute_ff;

   // Stage 6: whole hours and the remaining fraction of an hour.
   always_comb begin
      h_prod  = H_W'(frac) * HOURS_PER_DAY;
      hour_in = h_prod[FRAC_BITS +: HOUR_W];
      rest_in = h_prod[FRAC_BITS-1:0];
   end

   // Stage 7: whole minutes.
   always_comb begin
      m_prod    = M_W'(rest_ff) * MINUTES_PER_HOUR;
      minute_in = m_prod[FRAC_BITS +: MIN_W];
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[6]) begin
         hour_ff <= hour_in;
         rest_ff <= rest_in;
      end
      if (ctrl.load[7]) begin
         hour_out_ff <= hour_ff;
         minute_ff   <= minute_in;
      end
   end

   assign hour   = hour_out_ff;
   assign minute = minute_ff;
endmodule

/* rtl/core/julian_day_to_day_of_year.sv */
// Channel  Direction  Transfer contents
// req_ch   in         julian_date (39 bits, 16 fraction bits), leap_year
// rsp_ch   out        year_day, month, day_of_month, hour, minute
// csr_*    in         julian_cutover, written whenever csr_we is high
//
// One date is taken every cycle unless a stall on rsp_ch holds req_ch; each
// result passes through eight register stages, each holding at most one
// constant multiply with the adds and lookups around it.
// Reset clears every stage valid bit and loads the cutover with 2361221.
// A stage holds while the one after it is full and held, so a stall on rsp_ch
// reaches req_ch only once every stage is full; bubbles close up meanwhile.
`include "julian_day_to_day_of_year_assert.svh"

module julian_day_to_day_of_year (
   input  logic                       clock,
   input  logic                       reset,
   jdoy_req_if.sink                   req_ch,
   jdoy_rsp_if.source                 rsp_ch,
   input  logic                       csr_we,
   input  logic [jdoy_pkg::CUT_W-1:0] csr_wdata
);
   import jdoy_pkg::*;

   // The cutover is the last day number decoded with Julian calendar rules.
   logic [CUT_W-1:0]  cutover_ff, cutover_in;

   // One valid bit per stage travels alongside the data in the submodules.
   logic [STAGES-1:0] valid_ff, valid_in;
   logic [STAGES-1:0] up_valid;
   logic [STAGES:0]   stage_ready;
   pipe_ctrl_type     ctrl;

   split_type         split;
   cycle_type         cycle;
   year_type          year;

   // Conditions watched by the checks at the end of the module.
   logic              full_and_held;
   logic              last_leaves_alone;
   logic              result_in_range;

   assign cutover_in = csr_we ? csr_wdata : cutover_ff;

   // A stage can take a new item when it is empty or when its current item
   // moves on in the same cycle. The chain runs from the output back to the
   // input, so the handshake stays correct under any stall pattern.
   always_comb begin
      up_valid              = {valid_ff[STAGES-2:0], req_ch.valid};
      stage_ready[STAGES]   = rsp_ch.ready;
      for (int i = STAGES - 1; i >= 0; i--) begin
         stage_ready[i] = !valid_ff[i] || stage_ready[i+1];
      end
      ctrl.load = up_valid & stage_ready[STAGES-1:0];
      for (int i = 0; i < STAGES; i++) begin
         valid_in[i] = stage_ready[i] ? up_valid[i] : valid_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= '0;
         cutover_ff <= CUTOVER_RESET;
      end else begin
         valid_ff   <= valid_in;
         cutover_ff <= cutover_in;
      end
   end

   assign req_ch.ready = stage_ready[0];
   assign rsp_ch.valid = valid_ff[STAGES-1];

   // Stages 0 and 1: half-day rounding, day split and calendar choice.
   jdoy_day_split u_split (
      .clock       (clock),
      .ctrl        (ctrl),
      .julian_date (req_ch.julian_date),
      .leap_year   (req_ch.leap_year),
      .cutover     (cutover_ff),
      .split       (split)
   );

   // Stages 2 and 3: removal of whole four-century cycles.
   jdoy_cycle_div u_cycle (
      .clock (clock),
      .ctrl  (ctrl),
      .split (split),
      .cycle (cycle)
   );

   // Stages 4 and 5: removal of whole years within the cycle.
   jdoy_year_div u_year (
      .clock (clock),
      .ctrl  (ctrl),
      .cycle (cycle),
      .year  (year)
   );

   // Stages 6 and 7: month, day and day of year from the March-based index.
   jdoy_month_dec u_month (
      .clock        (clock),
      .ctrl         (ctrl),
      .year         (year),
      .year_day     (rsp_ch.year_day),
      .month        (rsp_ch.month),
      .day_of_month (rsp_ch.day_of_month)
   );

   // Stages 6 and 7 in parallel: hour and minute from the day fraction, which
   // rides along with the date so that both halves leave together.
   jdoy_clock_dec u_clock (
      .clock  (clock),
      .ctrl   (ctrl),
      .frac   (year.frac),
      .hour   (rsp_ch.hour),
      .minute (rsp_ch.minute)
   );

   assign full_and_held     = (&valid_ff) && !rsp_ch.ready;
   assign last_leaves_alone = valid_ff[STAGES-1] && rsp_ch.ready && !valid_ff[STAGES-2];
   assign result_in_range   = (rsp_ch.month >= 4'd1) && (rsp_ch.month <= 4'd12) &&
                              (rsp_ch.hour <= 5'd23) && (rsp_ch.minute <= 6'd59);

   // With every stage full and the output held, no new transfer may come in.
   `JDOY_ASSERT_SAME(a_full_holds_input, clock, reset, full_and_held, !req_ch.ready)
   // An accepted date always lands in the first stage.
   `JDOY_ASSERT_NEXT(a_accept_lands, clock, reset, req_ch.valid && req_ch.ready, valid_ff[0])
   // The last stage empties when its result leaves and nothing follows it.
   `JDOY_ASSERT_NEXT(a_last_drains, clock, reset, last_leaves_alone, !valid_ff[STAGES-1])
   // Decoded results always lie in calendar and clock range.
   `JDOY_ASSERT_SAME(a_result_range, clock, reset, rsp_ch.valid, result_in_range)

endmodule
